FILE: src/lkvc_pkg.sv
// Package for the LRU key-value cache: shared types, field widths and codes.
// Used by lkvc_cell, lru_key_value_cache_core and the testbench; depends on nothing else.
package lkvc_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes carried on s_tuser
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic
    {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    // One stored entry as it moves between neighboring cells
    typedef struct packed
    {
        logic                     valid;
        logic signed [KEY_W-1:0]  key;
        logic signed [DATA_W-1:0] data;
    } entry_t;

endpackage

FILE: src/lkvc_cell.sv
// One cell of the recency-ordered entry chain: holds one entry, compares its key,
// and loads its upstream neighbor's entry when told to shift. Depends on lkvc_pkg.
module lkvc_cell
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 shift_en,
    input  logic                                 keep,
    input  lkvc_pkg::entry_t                     up,
    input  logic signed [lkvc_pkg::KEY_W-1:0]    cmp_key,
    output lkvc_pkg::entry_t                     q,
    output logic                                 match
);

    logic                                valid_reg;
    logic                                valid_next;
    logic signed [lkvc_pkg::KEY_W-1:0]   key_reg;
    logic signed [lkvc_pkg::DATA_W-1:0]  data_reg;

    // Take the neighbor's valid bit on a shift, dropped past the capacity limit
    always_comb
    begin
        valid_next = valid_reg;
        if (shift_en)
        begin
            valid_next = up.valid & keep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Advance key and data along the chain
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            key_reg  <= up.key;
            data_reg <= up.data;
        end
    end

    // Compare against the key being looked up
    assign match = valid_reg && (key_reg == cmp_key);
    assign q     = '{valid: valid_reg, key: key_reg, data: data_reg};

endmodule

FILE: src/lru_key_value_cache_core.sv
// Top level of the LRU key-value cache: a chain of lkvc_cell instances ordered by
// recency, plus lookup sequencing and the result register. Depends on lkvc_pkg, lkvc_cell.
//
//  Channel | Signals                                  | Word contents (low bit up)
//  --------+------------------------------------------+--------------------------------
//  s_      | s_tvalid, s_tready, s_tdata[63:0], s_tuser | tdata: key, write_data; tuser: op
//  m_      | m_tvalid, m_tready, m_tdata[31:0], m_tuser | tdata: read_data; tuser: hit
//  cfg_    | cfg_wr_en, cfg_wr_data[4:0]               | capacity
//
// For each word, the accept edge registers the key compare of every cell; the update state
// that follows shifts the cell chain (hit or insert) and, on a get, loads the result register.
// Cell 0 holds the most recent entry; the oldest live entry sits at the far end.
// Reset clears all valid bits at once and sets capacity to 16; no clearing pass.
// A stalled m_ side holds a get result; a new word is taken only once the result
// register will be free by the time that word finishes.
module lru_key_value_cache_core
#(
    parameter int ENTRIES = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // key [31:0], write_data [63:32]
    input  logic [63:0]                 s_tdata,
    // op [0]
    input  logic                        s_tuser,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // read_data [31:0]
    output logic [31:0]                 m_tdata,
    // hit [0]
    output logic                        m_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic                        cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0]  cfg_wr_data
);

    lkvc_pkg::state_t                        state_reg;
    lkvc_pkg::state_t                        state_next;

    logic                                    op_reg;
    logic signed [lkvc_pkg::KEY_W-1:0]       key_reg;
    logic signed [lkvc_pkg::DATA_W-1:0]      wdata_reg;
    logic [ENTRIES-1:0]                      match_reg;
    logic [lkvc_pkg::CAP_W-1:0]              cap_reg;

    logic                                    out_valid_reg;
    logic                                    out_hit_reg;
    logic signed [lkvc_pkg::DATA_W-1:0]      out_data_reg;

    logic                                    accept;
    logic                                    update_en;
    logic                                    hit;
    logic                                    miss_insert;
    logic                                    apply;
    logic signed [lkvc_pkg::KEY_W-1:0]       cmp_key;
    logic signed [lkvc_pkg::DATA_W-1:0]      hit_data;
    logic [lkvc_pkg::CAP_W-1:0]              cap_eff;
    lkvc_pkg::entry_t                        new_entry;

    lkvc_pkg::entry_t                        cell_q  [ENTRIES];
    lkvc_pkg::entry_t                        cell_up [ENTRIES];
    logic [ENTRIES-1:0]                      match_vec;
    logic [ENTRIES-1:0]                      shift_vec;
    logic [ENTRIES-1:0]                      keep_vec;
    logic [ENTRIES-1:0]                      valid_vec;

    assign cmp_key = s_tdata[lkvc_pkg::KEY_W-1:0];
    assign accept  = s_tvalid && s_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = lkvc_pkg::ST_UPDATE;
                end
            end
            lkvc_pkg::ST_UPDATE:
            begin
                state_next = lkvc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready  = 1'b0;
        update_en = 1'b0;
        case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                s_tready = !out_valid_reg || m_tready;
            end
            lkvc_pkg::ST_UPDATE:
            begin
                update_en = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lkvc_pkg::ST_IDLE;
            match_reg <= '0;
            cap_reg   <= lkvc_pkg::CAP_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                match_reg <= match_vec;
            end
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // Hold the accepted word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= s_tuser;
            key_reg   <= s_tdata[lkvc_pkg::KEY_W-1:0];
            wdata_reg <= s_tdata[lkvc_pkg::KEY_W +: lkvc_pkg::DATA_W];
        end
    end

    // Clamp capacity to 1..ENTRIES
    always_comb
    begin
        cap_eff = cap_reg;
        if (cap_reg == '0)
        begin
            cap_eff = lkvc_pkg::CAP_W'(1);
        end
        else if (32'(cap_reg) > 32'(ENTRIES))
        begin
            cap_eff = lkvc_pkg::CAP_W'(ENTRIES);
        end
    end

    // Select the data of the matching cell
    always_comb
    begin
        hit_data = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_reg[i])
            begin
                hit_data = hit_data | cell_q[i].data;
            end
        end
    end

    assign hit         = |match_reg;
    assign miss_insert = (op_reg == lkvc_pkg::OP_PUT) && !hit;
    assign apply       = update_en && ((op_reg == lkvc_pkg::OP_PUT) || hit);

    assign new_entry.valid = 1'b1;
    assign new_entry.key   = key_reg;
    assign new_entry.data  = (op_reg == lkvc_pkg::OP_PUT) ? wdata_reg : hit_data;

    // Shift cells up to the hit position, or the whole chain on an insert;
    // on an insert, drop entries that fall at or past the capacity
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            shift_vec[i] = apply && (miss_insert || (|(match_reg >> i)));
            keep_vec[i]  = !miss_insert || (32'(i) < 32'(cap_eff));
        end
    end

    // Chain of cells, most recent first
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            assign cell_up[g] = new_entry;
        end
        else
        begin : g_body
            assign cell_up[g] = cell_q[g-1];
        end

        lkvc_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_vec[g]),
            .keep     (keep_vec[g]),
            .up       (cell_up[g]),
            .cmp_key  (cmp_key),
            .q        (cell_q[g]),
            .match    (match_vec[g])
        );

        assign valid_vec[g] = cell_q[g].valid;
    end

    // Result register: load on a get, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (update_en && (op_reg == lkvc_pkg::OP_GET))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (update_en && (op_reg == lkvc_pkg::OP_GET))
        begin
            out_hit_reg  <= hit;
            out_data_reg <= hit ? hit_data : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // A key lives in at most one cell
    a_match_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        update_en |-> $onehot0(match_reg))
        else $error("more than one cell matched the key");

    // Live entries always fill the chain from the head without gaps
    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("live entries are not packed at the head of the chain");

    // A get that is taken has its result valid once its update state is over
    a_get_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == lkvc_pkg::OP_GET)) |=> ##1 m_tvalid)
        else $error("get did not produce a result");

    // An insert leaves no more live entries than the capacity
    a_insert_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (update_en && miss_insert) |=> ($countones(valid_vec) <= 32'(cap_eff)))
        else $error("insert left more live entries than the capacity");
`endif

endmodule

FILE: sim/tb_lru_key_value_cache_core.sv
// Testbench for lru_key_value_cache_core: directed and random get/put words checked
// against an in-bench LRU predictor. Depends on lkvc_pkg and the cache core RTL.
module tb_lru_key_value_cache_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LINES       = 16;
    localparam int          SETTLE_CYC  = 6;
    localparam logic [31:0] KEY_MIN     = 32'h8000_0000;
    localparam logic [31:0] KEY_MAX     = 32'h7FFF_FFFF;

    // One live cache line as the predictor keeps it
    typedef struct
    {
        logic [lkvc_pkg::KEY_W-1:0]  key;
        logic [lkvc_pkg::DATA_W-1:0] data;
    } cache_line_t;

    // What a get word must return
    typedef struct
    {
        logic                        hit;
        logic [lkvc_pkg::DATA_W-1:0] read_data;
        logic [lkvc_pkg::KEY_W-1:0]  key;
        int                          word_no;
    } lookup_result_t;

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic [63:0]                    s_tdata     = '0;
    logic                           s_tuser     = lkvc_pkg::OP_GET;
    logic                           s_tvalid    = 1'b0;
    logic                           s_tready;
    logic [31:0]                    m_tdata;
    logic                           m_tuser;
    logic                           m_tvalid;
    logic                           m_tready    = 1'b0;
    logic                           cfg_wr_en   = 1'b0;
    logic [lkvc_pkg::CAP_W-1:0]     cfg_wr_data = lkvc_pkg::CAP_RESET;

    // Predictor state: live lines, most recent first, and the raw capacity register
    cache_line_t                    lru_lines[$];
    logic [lkvc_pkg::CAP_W-1:0]     capacity_reg = lkvc_pkg::CAP_RESET;
    lookup_result_t                 pending_lookups[$];
    lookup_result_t                 oldest_lookup;

    int                             mismatch_count  = 0;
    int                             words_sent      = 0;
    int                             gets_sent       = 0;
    int                             puts_sent       = 0;
    int                             results_checked = 0;
    int                             cap_writes      = 0;
    bit                             src_gaps        = 1'b1;
    bit                             sink_stalls     = 1'b1;
    int                             sink_hold       = 0;
    int                             sink_roll;
    logic [lkvc_pkg::KEY_W-1:0]     key_pool[$];

    lru_key_value_cache_core #(.ENTRIES(LINES)) dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int effective_capacity();
        if (capacity_reg == '0)
            return 1;
        if (int'(capacity_reg) > LINES)
            return LINES;
        return int'(capacity_reg);
    endfunction

    function automatic int find_line(logic [lkvc_pkg::KEY_W-1:0] k);
        foreach (lru_lines[i])
        begin
            if (lru_lines[i].key == k)
                return i;
        end
        return -1;
    endfunction

    // Apply one accepted word to the predictor; a get queues its expected result
    function automatic void lookup_or_store(logic op, logic [lkvc_pkg::KEY_W-1:0] k,
                                            logic [lkvc_pkg::DATA_W-1:0] d, int word_no);
        int             idx;
        cache_line_t    line;
        lookup_result_t res;
        idx = find_line(k);
        if (op == lkvc_pkg::OP_GET)
        begin
            res.hit       = (idx >= 0);
            res.read_data = '0;
            res.key       = k;
            res.word_no   = word_no;
            if (idx >= 0)
            begin
                // promote the hit line to most recent
                line = lru_lines[idx];
                lru_lines.delete(idx);
                lru_lines.push_front(line);
                res.read_data = line.data;
            end
            pending_lookups.push_back(res);
        end
        else if (idx >= 0)
        begin
            // update the existing line and promote it to most recent, no eviction
            line      = lru_lines[idx];
            line.data = d;
            lru_lines.delete(idx);
            lru_lines.push_front(line);
        end
        else
        begin
            // evict oldest lines until there is room under the capacity
            while (lru_lines.size() >= effective_capacity() && lru_lines.size() > 0)
                void'(lru_lines.pop_back());
            line.key  = k;
            line.data = d;
            lru_lines.push_front(line);
        end
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Compare each returned word with the oldest pending lookup
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_lookups.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending: hit=%0b data=%h",
                                          m_tuser, m_tdata));
            end
            else
            begin
                oldest_lookup = pending_lookups.pop_front();
                results_checked++;
                if (m_tuser !== oldest_lookup.hit)
                    report_mismatch($sformatf("word %0d key %h: hit %0b, want %0b",
                                              oldest_lookup.word_no, oldest_lookup.key,
                                              m_tuser, oldest_lookup.hit));
                if (m_tdata !== oldest_lookup.read_data)
                    report_mismatch($sformatf("word %0d key %h: read_data %h, want %h",
                                              oldest_lookup.word_no, oldest_lookup.key,
                                              m_tdata, oldest_lookup.read_data));
            end
        end
    end

    // Result side back-pressure: mostly ready, short stalls, an occasional long one
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready = 1'b0;
        else if (!sink_stalls)
            m_tready = 1'b1;
        else if (sink_hold > 0)
        begin
            m_tready  = 1'b0;
            sink_hold = sink_hold - 1;
        end
        else
        begin
            sink_roll = $urandom_range(0, 99);
            if (sink_roll < 65)
                m_tready = 1'b1;
            else
            begin
                m_tready  = 1'b0;
                sink_hold = (sink_roll < 92) ? $urandom_range(0, 2) : $urandom_range(8, 30);
            end
        end
    end

    // ---------------------------------------------------------------- driving

    function automatic int pick_gap();
        int r;
        if (!src_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Present one word at the falling edge and hold it until accepted
    task automatic send_word(logic op, logic [lkvc_pkg::KEY_W-1:0] k,
                             logic [lkvc_pkg::DATA_W-1:0] d);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {d, k};
        s_tuser  = op;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        lookup_or_store(op, k, d, words_sent);
        words_sent++;
        if (op == lkvc_pkg::OP_GET)
            gets_sent++;
        else
            puts_sent++;
    endtask

    // Drop valid and hold off until every pending result has come back
    task automatic wait_for_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_lookups.size() != 0)
            @(negedge clk);
    endtask

    // Drain, then let a trailing put finish inside the block
    task automatic wait_idle();
        wait_for_results();
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_capacity(logic [lkvc_pkg::CAP_W-1:0] value);
        wait_idle();
        cfg_wr_data = value;
        cfg_wr_en   = 1'b1;
        @(posedge clk);
        capacity_reg = value;
        cap_writes++;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // ---------------------------------------------------------------- tests

    // Empty lookup, field extremes, update of an existing key
    task automatic test_basic_access();
        send_word(lkvc_pkg::OP_GET, 32'd0,   32'd0);
        send_word(lkvc_pkg::OP_PUT, KEY_MIN, 32'h7FFF_FFFF);
        send_word(lkvc_pkg::OP_PUT, KEY_MAX, 32'h8000_0000);
        send_word(lkvc_pkg::OP_PUT, 32'd0,   32'd0);
        send_word(lkvc_pkg::OP_PUT, '1,      32'd1);
        send_word(lkvc_pkg::OP_GET, KEY_MIN, '1);
        send_word(lkvc_pkg::OP_GET, KEY_MAX, '0);
        send_word(lkvc_pkg::OP_GET, 32'd0,   32'hDEAD_BEEF);
        send_word(lkvc_pkg::OP_GET, '1,      32'd0);
        send_word(lkvc_pkg::OP_PUT, KEY_MAX, 32'h5A5A_A5A5);
        send_word(lkvc_pkg::OP_GET, KEY_MAX, 32'd0);
        send_word(lkvc_pkg::OP_GET, 32'd1,   32'd0);
    endtask

    // Least recent line goes first once the capacity is reached
    task automatic test_eviction_order();
        write_capacity(5'd2);
        send_word(lkvc_pkg::OP_PUT, 32'd10, 32'hA0A0_0010);
        send_word(lkvc_pkg::OP_PUT, 32'd20, 32'hA0A0_0020);
        send_word(lkvc_pkg::OP_GET, 32'd10, 32'd0);
        send_word(lkvc_pkg::OP_PUT, 32'd30, 32'hA0A0_0030);
        send_word(lkvc_pkg::OP_GET, 32'd20, 32'd0);
        send_word(lkvc_pkg::OP_GET, 32'd10, 32'd0);
        send_word(lkvc_pkg::OP_GET, 32'd30, 32'd0);
    endtask

    // Capacity zero acts as one; lowering below the live count evicts on next insert only
    task automatic test_capacity_lowered();
        write_capacity(5'd0);
        send_word(lkvc_pkg::OP_PUT, 32'd30, 32'hB0B0_0030);
        send_word(lkvc_pkg::OP_GET, 32'd10, 32'd0);
        send_word(lkvc_pkg::OP_PUT, 32'd40, 32'hB0B0_0040);
        send_word(lkvc_pkg::OP_GET, 32'd10, 32'd0);
        send_word(lkvc_pkg::OP_GET, 32'd30, 32'd0);
        send_word(lkvc_pkg::OP_GET, 32'd40, 32'd0);
    endtask

    // Random gets and puts over a small key pool, one capacity setting per phase
    task automatic test_random_traffic();
        logic [lkvc_pkg::CAP_W-1:0] caps[9];
        int                         pool_size;
        logic [lkvc_pkg::KEY_W-1:0] k;
        logic                       op;
        caps = '{5'd16, 5'd1, 5'd3, 5'd31, 5'd0, 5'd17, 5'd7, 5'd2, 5'd16};
        foreach (caps[p])
        begin
            write_capacity(caps[p]);
            src_gaps    = (p % 3 != 1);
            sink_stalls = (p % 3 != 1);
            key_pool.delete();
            pool_size = effective_capacity() + $urandom_range(1, 4);
            if (p == 0)
            begin
                key_pool.push_back(KEY_MIN);
                key_pool.push_back(KEY_MAX);
                key_pool.push_back('0);
                key_pool.push_back('1);
            end
            while (key_pool.size() < pool_size)
                key_pool.push_back($urandom());
            for (int n = 0; n < 75; n++)
            begin
                if (n == 30 || $urandom_range(0, 39) == 0)
                    wait_for_results();
                if ($urandom_range(0, 9) == 0)
                    k = $urandom();
                else
                    k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                op = ($urandom_range(0, 99) < 50) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET;
                send_word(op, k, $urandom());
            end
        end
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_access();
        test_eviction_order();
        test_capacity_lowered();
        test_random_traffic();

        wait_idle();
        repeat (10) @(negedge clk);
        foreach (pending_lookups[i])
            report_mismatch($sformatf("word %0d key %h: result never returned",
                                      pending_lookups[i].word_no, pending_lookups[i].key));

        $display("Sent %0d words (%0d gets, %0d puts) and checked %0d lookup results,",
                 words_sent, gets_sent, puts_sent, results_checked);
        $display("across %0d capacity writes including zero, one, sixteen and saturating values.",
                 cap_writes);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Run timed out with %0d lookups outstanding", pending_lookups.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
src/lkvc_pkg.sv
src/lkvc_cell.sv
src/lru_key_value_cache_core.sv
sim/tb_lru_key_value_cache_core.sv
